// ===== hdl/hlsm_pkg.sv =====
// ----------------------------------------------------------------------------
// hlsm_pkg
// shared types and constants for the hough line sort and merge block
// ----------------------------------------------------------------------------
package hlsm_pkg;

    localparam int RHO_W   = 17;
    localparam int THETA_W = 16;
    localparam int SIZE_W  = 7;
    localparam int THR_W   = 16;
    localparam int MAX_LINES_DEF = 64;

    localparam logic [1:0] REG_SORT_KEY  = 2'd0;
    localparam logic [1:0] REG_RHO_THR   = 2'd1;
    localparam logic [1:0] REG_THETA_THR = 2'd2;

    localparam logic [THR_W-1:0] RHO_THR_RST   = 16'd208;
    localparam logic [THR_W-1:0] THETA_THR_RST = 16'd295;

    typedef struct packed {
        logic signed [RHO_W-1:0] rho;
        logic [THETA_W-1:0]      theta;
    } hline_t;

    // divider request and result between sequencer and divider
    typedef struct packed {
        logic              start;
        logic              neg;
        logic [31:0]       dividend;
        logic [SIZE_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
    } div_rsp_t;

endpackage

// ===== hdl/hlsm_div.sv =====
// ----------------------------------------------------------------------------
// hlsm_div
// restoring divider, one quotient bit per cycle, sign applied at the end
// ----------------------------------------------------------------------------
module hlsm_div
(
    input  logic               clk,
    input  logic               rst_n,
    input  hlsm_pkg::div_req_t req,
    output hlsm_pkg::div_rsp_t rsp
);

    logic [31:0]                 quot_reg, quot_next;
    logic [hlsm_pkg::SIZE_W:0]   rem_reg, rem_next;
    logic [hlsm_pkg::SIZE_W-1:0] dvs_reg, dvs_next;
    logic                        neg_reg, neg_next;
    logic [5:0]                  cnt_reg, cnt_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [hlsm_pkg::SIZE_W+1:0] trial;
    logic [hlsm_pkg::SIZE_W:0]   shifted;

    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg[hlsm_pkg::SIZE_W-1:0], quot_reg[31]};
        trial     = {1'b0, shifted} - {2'b00, dvs_reg};
        if (req.start)
        begin
            quot_next = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
            neg_next  = req.neg;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[hlsm_pkg::SIZE_W+1])
            begin
                rem_next  = trial[hlsm_pkg::SIZE_W:0];
                quot_next = {quot_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next  = shifted;
                quot_next = {quot_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        neg_reg  <= neg_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = neg_reg ? (32'd0 - quot_reg) : quot_reg;

endmodule

// ===== hdl/hlsm_seq.sv =====
// ----------------------------------------------------------------------------
// hlsm_seq
// line store, compare-swap sort and group merge sequencer
// ----------------------------------------------------------------------------
module hlsm_seq
#(
    parameter int MAX_LINES = hlsm_pkg::MAX_LINES_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  hlsm_pkg::hline_t             in_line,
    input  logic                         in_last,
    input  logic                         sort_key,
    input  logic [hlsm_pkg::THR_W-1:0]   rho_thr,
    input  logic [hlsm_pkg::THR_W-1:0]   theta_thr,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [hlsm_pkg::RHO_W-1:0]   out_rho,
    output logic [hlsm_pkg::THETA_W-1:0] out_theta,
    output logic [hlsm_pkg::SIZE_W-1:0]  out_size,
    output logic                         out_drop,
    output logic                         out_final,
    output hlsm_pkg::div_req_t           div_req,
    input  hlsm_pkg::div_rsp_t           div_rsp
);

    localparam int AW = $clog2(MAX_LINES);
    localparam int CW = $clog2(MAX_LINES + 1);

    typedef enum logic [9:0] {
        S_LOAD  = 10'b0000000001,
        S_SRD   = 10'b0000000010,
        S_SCMP  = 10'b0000000100,
        S_SWR   = 10'b0000001000,
        S_MRD   = 10'b0000010000,
        S_MACC  = 10'b0000100000,
        S_DIVR  = 10'b0001000000,
        S_DIVT  = 10'b0010000000,
        S_OUT   = 10'b0100000000,
        S_WAIT  = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    hlsm_pkg::hline_t mem [MAX_LINES];
    hlsm_pkg::hline_t rd_a_reg, rd_b_reg;
    logic [AW-1:0]    ra_a, ra_b;
    logic             we_a, we_b;
    logic [AW-1:0]    wa_a, wa_b;
    hlsm_pkg::hline_t wd_a, wd_b;

    logic [CW-1:0]   count_reg, count_next;
    logic            ovf_reg, ovf_next;
    logic [CW-1:0]   j_reg, j_next;
    logic            swapped_reg, swapped_next;
    logic [CW-1:0]   pass_reg, pass_next;
    logic [CW-1:0]   i_reg, i_next;
    hlsm_pkg::hline_t prev_reg, prev_next;
    logic signed [23:0] sr_reg, sr_next;
    logic [22:0]     st_reg, st_next;
    logic [hlsm_pkg::SIZE_W-1:0] gsz_reg, gsz_next;
    logic            gfin_reg, gfin_next;
    logic [hlsm_pkg::RHO_W-1:0]   qrho_reg, qrho_next;
    logic [hlsm_pkg::THETA_W-1:0] qth_reg, qth_next;
    logic [hlsm_pkg::RHO_W-1:0]   orho_reg, orho_next;
    logic [hlsm_pkg::THETA_W-1:0] oth_reg, oth_next;
    logic [hlsm_pkg::SIZE_W-1:0]  osz_reg, osz_next;
    logic            ofin_reg, ofin_next;
    logic            odrop_reg, odrop_next;
    logic            ovalid_reg, ovalid_next;
    logic            first_reg, first_next;

    logic            gt;
    logic signed [18:0] dr;
    logic signed [17:0] dt;
    logic [16:0]     adt;
    logic            join_grp;

    always_ff @(posedge clk)
    begin
        if (we_a) mem[wa_a] <= wd_a;
        if (we_b) mem[wa_b] <= wd_b;
        rd_a_reg <= mem[ra_a];
        rd_b_reg <= mem[ra_b];
    end

    assign gt = sort_key ? (rd_a_reg.theta > rd_b_reg.theta)
                         : (rd_a_reg.rho > rd_b_reg.rho);
    assign dr = {{2{rd_a_reg.rho[16]}}, rd_a_reg.rho} - {{2{prev_reg.rho[16]}}, prev_reg.rho};
    assign dt = {2'b00, rd_a_reg.theta} - {2'b00, prev_reg.theta};
    assign adt = dt[17] ? 17'(-dt) : dt[16:0];
    assign join_grp = (dr <= $signed({3'b000, rho_thr})) && ({1'b0, adt} <= {2'b00, theta_thr});

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        ovf_next     = ovf_reg;
        j_next       = j_reg;
        swapped_next = swapped_reg;
        pass_next    = pass_reg;
        i_next       = i_reg;
        prev_next    = prev_reg;
        sr_next      = sr_reg;
        st_next      = st_reg;
        gsz_next     = gsz_reg;
        gfin_next    = gfin_reg;
        qrho_next    = qrho_reg;
        qth_next     = qth_reg;
        orho_next    = orho_reg;
        oth_next     = oth_reg;
        osz_next     = osz_reg;
        ofin_next    = ofin_reg;
        odrop_next   = odrop_reg;
        ovalid_next  = ovalid_reg;
        first_next   = first_reg;
        ra_a = AW'(j_reg - CW'(1));
        ra_b = j_reg[AW-1:0];
        we_a = 1'b0;
        we_b = 1'b0;
        wa_a = AW'(j_reg - CW'(1));
        wa_b = j_reg[AW-1:0];
        wd_a = rd_b_reg;
        wd_b = rd_a_reg;
        in_ready = 1'b0;
        div_req  = '0;

        if (ovalid_reg && out_ready)
            ovalid_next = 1'b0;

        case (state_reg)
            S_LOAD:
            begin
                in_ready = 1'b1;
                wa_a = count_reg[AW-1:0];
                wd_a = in_line;
                if (in_valid)
                begin
                    if (count_reg < CW'(MAX_LINES))
                    begin
                        we_a = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                    else
                        ovf_next = 1'b1;
                    if (in_last)
                    begin
                        j_next = CW'(1);
                        pass_next = '0;
                        swapped_next = 1'b0;
                        state_next = S_SRD;
                    end
                end
            end
            S_SRD:
            begin
                if (j_reg >= count_next)
                begin
                    pass_next = pass_reg + CW'(1);
                    if (!swapped_reg || (pass_reg + CW'(1)) >= count_reg)
                    begin
                        i_next = '0;
                        first_next = 1'b1;
                        state_next = S_MRD;
                    end
                    else
                    begin
                        j_next = CW'(1);
                        swapped_next = 1'b0;
                    end
                end
                else
                    state_next = S_SCMP;
            end
            S_SCMP:
            begin
                if (gt)
                begin
                    swapped_next = 1'b1;
                    state_next = S_SWR;
                end
                else
                begin
                    j_next = j_reg + CW'(1);
                    state_next = S_SRD;
                end
            end
            S_SWR:
            begin
                we_a = 1'b1;
                we_b = 1'b1;
                j_next = j_reg + CW'(1);
                state_next = S_SRD;
            end
            S_MRD:
            begin
                ra_a = i_reg[AW-1:0];
                state_next = S_MACC;
            end
            S_MACC:
            begin
                if (first_reg || join_grp)
                begin
                    sr_next  = (first_reg ? 24'sd0 : sr_reg) + 24'(rd_a_reg.rho);
                    st_next  = (first_reg ? 23'd0 : st_reg) + 23'(rd_a_reg.theta);
                    gsz_next = (first_reg ? '0 : gsz_reg) + 1'b1;
                    first_next = 1'b0;
                    prev_next = rd_a_reg;
                    i_next = i_reg + CW'(1);
                    if (i_reg + CW'(1) >= count_reg)
                    begin
                        gfin_next = 1'b1;
                        state_next = S_DIVR;
                        div_req.start = 1'b1;
                        div_req.neg = sr_next[23];
                        div_req.dividend = 32'(sr_next[23] ? -sr_next : sr_next);
                        div_req.divisor = gsz_next;
                    end
                    else
                        state_next = S_MRD;
                end
                else
                begin
                    gfin_next = 1'b0;
                    state_next = S_DIVR;
                    div_req.start = 1'b1;
                    div_req.neg = sr_reg[23];
                    div_req.dividend = 32'(sr_reg[23] ? -sr_reg : sr_reg);
                    div_req.divisor = gsz_reg;
                end
            end
            S_DIVR:
            begin
                if (div_rsp.done)
                begin
                    qrho_next = div_rsp.quotient[hlsm_pkg::RHO_W-1:0];
                    div_req.start = 1'b1;
                    div_req.dividend = 32'(st_reg);
                    div_req.divisor = gsz_reg;
                    state_next = S_DIVT;
                end
            end
            S_DIVT:
            begin
                if (div_rsp.done)
                begin
                    qth_next = div_rsp.quotient[hlsm_pkg::THETA_W-1:0];
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!ovalid_reg || out_ready)
                begin
                    ovalid_next = 1'b1;
                    orho_next = qrho_reg;
                    oth_next = qth_reg;
                    osz_next = gsz_reg;
                    ofin_next = gfin_reg;
                    odrop_next = ovf_reg;
                    if (gfin_reg)
                    begin
                        count_next = '0;
                        ovf_next = 1'b0;
                        state_next = S_WAIT;
                    end
                    else
                    begin
                        first_next = 1'b1;
                        state_next = S_MRD;
                    end
                end
            end
            S_WAIT:
            begin
                if (!ovalid_next)
                    state_next = S_LOAD;
            end
            default:
                state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_LOAD;
            count_reg  <= '0;
            ovf_reg    <= 1'b0;
            ovalid_reg <= 1'b0;
            first_reg  <= 1'b1;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            ovf_reg    <= ovf_next;
            ovalid_reg <= ovalid_next;
            first_reg  <= first_next;
        end
    end

    always_ff @(posedge clk)
    begin
        j_reg       <= j_next;
        swapped_reg <= swapped_next;
        pass_reg    <= pass_next;
        i_reg       <= i_next;
        prev_reg    <= prev_next;
        sr_reg      <= sr_next;
        st_reg      <= st_next;
        gsz_reg     <= gsz_next;
        gfin_reg    <= gfin_next;
        qrho_reg    <= qrho_next;
        qth_reg     <= qth_next;
        orho_reg    <= orho_next;
        oth_reg     <= oth_next;
        osz_reg     <= osz_next;
        ofin_reg    <= ofin_next;
        odrop_reg   <= odrop_next;
    end

    assign out_valid = ovalid_reg;
    assign out_rho   = orho_reg;
    assign out_theta = oth_reg;
    assign out_size  = osz_reg;
    assign out_drop  = odrop_reg;
    assign out_final = ofin_reg;

endmodule

// ===== hdl/hough_line_sort_and_merge.sv =====
// ----------------------------------------------------------------------------
// hough_line_sort_and_merge
// collects a set of hough lines, sorts them and merges close neighbours
// ----------------------------------------------------------------------------
// operation: lines load one per cycle; on set end a compare-swap sort of up to
//   n passes, then each group is accumulated line by line, its rho and theta sums
//   divided by its size in two divisions on the shared divider, and sent out
// throughput: one set at a time, input not ready from set end until the last
//   result is accepted
// reset: asynchronous for control registers; datapath and store left undefined
module hough_line_sort_and_merge
#(
    parameter int MAX_LINES = hlsm_pkg::MAX_LINES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // line_rho, line_theta, zero fill
    input  logic        s_tlast,   // set_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // merged_rho, merged_theta, group_size
    output logic        m_tuser,   // dropped_lines
    output logic        m_tlast,   // final_group
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic                          sort_key_reg;
    logic [hlsm_pkg::THR_W-1:0]    rho_thr_reg;
    logic [hlsm_pkg::THR_W-1:0]    theta_thr_reg;
    hlsm_pkg::hline_t              in_line;
    hlsm_pkg::div_req_t            div_req;
    hlsm_pkg::div_rsp_t            div_rsp;
    logic [hlsm_pkg::RHO_W-1:0]    o_rho;
    logic [hlsm_pkg::THETA_W-1:0]  o_theta;
    logic [hlsm_pkg::SIZE_W-1:0]   o_size;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sort_key_reg  <= 1'b0;
            rho_thr_reg   <= hlsm_pkg::RHO_THR_RST;
            theta_thr_reg <= hlsm_pkg::THETA_THR_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                hlsm_pkg::REG_SORT_KEY:  sort_key_reg  <= cfg_data[0];
                hlsm_pkg::REG_RHO_THR:   rho_thr_reg   <= cfg_data;
                hlsm_pkg::REG_THETA_THR: theta_thr_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign in_line.rho   = s_tdata[16:0];
    assign in_line.theta = s_tdata[32:17];

    hlsm_seq #(.MAX_LINES(MAX_LINES)) u_seq
    (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .in_line(in_line), .in_last(s_tlast),
        .sort_key(sort_key_reg), .rho_thr(rho_thr_reg), .theta_thr(theta_thr_reg),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .out_rho(o_rho), .out_theta(o_theta), .out_size(o_size),
        .out_drop(m_tuser), .out_final(m_tlast),
        .div_req(div_req), .div_rsp(div_rsp)
    );

    hlsm_div u_div
    (
        .clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp)
    );

    assign m_tdata = {o_size, o_theta, o_rho};

endmodule

// ===== hdl/hlsm_checker.sv =====
// ----------------------------------------------------------------------------
// hlsm_checker
// port level checks for hough_line_sort_and_merge
// ----------------------------------------------------------------------------
module hlsm_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tlast
);

    // a stalled word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable({m_tlast, m_tdata}))
        else $error("output word changed while stalled");

    // group size never zero
    a_size: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[39:33] != 7'd0)
        else $error("zero group size");

    // no input taken while results are out
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready)
        else $error("input accepted during merge");

    // set end stops input
    a_end: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("ready after set end");

endmodule

bind hough_line_sort_and_merge hlsm_checker u_hlsm_checker
(
    .clk(clk), .rst_n(rst_n),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
);
